### src/nap_pkg.sv
// Shared types and constants for the note arpeggiator.
`timescale 1ns / 1ps

package nap_pkg;

   localparam int NOTE_SLOTS_DEFAULT = 16;
   localparam int NOTE_W             = 7;
   localparam int VEL_W              = 7;
   localparam int ENTRY_W            = NOTE_W + VEL_W;
   localparam int DIV_W              = 7;
   localparam int COUNT_W            = 32;
   localparam int MOD_STEPS          = COUNT_W / 2;
   localparam int MOD_CNT_W          = $clog2(MOD_STEPS);

   localparam logic [DIV_W-1:0] DIV_RESET = DIV_W'(6);

   typedef enum logic [1:0] {
      OP_NOTE_ON  = 2'd0,
      OP_NOTE_OFF = 2'd1,
      OP_TICK     = 2'd2,
      OP_START    = 2'd3
   } op_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DISPATCH,
      ST_MOD,
      ST_TICK_CHECK,
      ST_RM_READ,
      ST_RM_CHECK,
      ST_EMIT
   } state_type;

   typedef struct packed {
      logic load_item;
      logic add_note;
      logic start;
      logic mod_step;
      logic rm_read;
      logic rm_check;
      logic rm_finish;
      logic step_pos;
      logic load_rsp;
   } cmd_type;

   typedef struct packed {
      op_type op;
      logic   mod_last;
      logic   rem_zero;
      logic   list_empty;
      logic   rm_done;
      logic   rsp_busy;
   } sts_type;

endpackage

### src/note_arpeggiator.sv
// Note arpeggiator: holds notes in arrival order and steps through them on clock ticks.
//
// The req channel carries one event per beat: note on, note off, clock tick or start.
// The rsp channel carries a note-on (note and velocity) for each tick that steps the
// arpeggio; other events give no beat. csr_write_enable writes the clock division.
// The block takes one event at a time. Note on and start are done in the dispatch
// state. Note off walks the held list through the note memory, reading and then
// checking each held entry in turn. A clock tick runs the count through a remainder
// unit that retires two bits a cycle; a stepping tick then moves the play position in
// the tick check state and loads its result beat into the output register in the
// emit state.
// A finished beat waits in the output register while rsp_ready is low; the next event
// is still accepted, and only a second stepping tick waits for the register to drain.
// Reset empties the list, sets the play position to 0 and the division to 6; the
// note memory itself is not cleared.
`timescale 1ns / 1ps

module note_arpeggiator #(
   parameter int NOTE_SLOTS = nap_pkg::NOTE_SLOTS_DEFAULT
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic [1:0]                    req_op,
   input  logic [nap_pkg::NOTE_W-1:0]    req_note,
   input  logic [nap_pkg::VEL_W-1:0]     req_velocity,
   input  logic [nap_pkg::COUNT_W-1:0]   req_clock_count,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [nap_pkg::NOTE_W-1:0]    rsp_play_note,
   output logic [nap_pkg::VEL_W-1:0]     rsp_play_velocity,
   input  logic                          csr_write_enable,
   input  logic [nap_pkg::DIV_W-1:0]     csr_write_data
);

   nap_pkg::cmd_type cmd;
   nap_pkg::sts_type sts;

   nap_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_ready (rsp_ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   nap_datapath #(
      .NOTE_SLOTS (NOTE_SLOTS)
   ) u_datapath (
      .clock             (clock),
      .reset             (reset),
      .req_op            (req_op),
      .req_note          (req_note),
      .req_velocity      (req_velocity),
      .req_clock_count   (req_clock_count),
      .csr_write_enable  (csr_write_enable),
      .csr_write_data    (csr_write_data),
      .rsp_ready         (rsp_ready),
      .rsp_valid         (rsp_valid),
      .rsp_play_note     (rsp_play_note),
      .rsp_play_velocity (rsp_play_velocity),
      .cmd               (cmd),
      .sts               (sts)
   );

`ifndef SYNTH
   // After an accepted event the block is not ready in the next cycle.
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("req_ready held high after an accepted beat");

   // A new result never overwrites a beat that is still waiting.
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      cmd.load_rsp |-> (!rsp_valid || rsp_ready))
      else $error("result register loaded while a beat was pending");

   // A result is only produced from a non-empty list.
   a_step_needs_notes: assert property (@(posedge clock) disable iff (reset)
      cmd.step_pos |-> !sts.list_empty)
      else $error("arpeggio stepped with an empty list");
`endif

endmodule

### src/nap_ctrl.sv
// Controller state machine that sequences each input item through the datapath.
`timescale 1ns / 1ps

module nap_ctrl (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  logic             rsp_ready,
   input  nap_pkg::sts_type sts,
   output nap_pkg::cmd_type cmd
);

   nap_pkg::state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= nap_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      case (state_ff)
         nap_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load_item = 1'b1;
               state_in      = nap_pkg::ST_DISPATCH;
            end
         end
         nap_pkg::ST_DISPATCH: begin
            case (sts.op)
               nap_pkg::OP_NOTE_ON: begin
                  cmd.add_note = 1'b1;
                  state_in     = nap_pkg::ST_IDLE;
               end
               nap_pkg::OP_NOTE_OFF: begin
                  state_in = nap_pkg::ST_RM_READ;
               end
               nap_pkg::OP_TICK: begin
                  state_in = nap_pkg::ST_MOD;
               end
               default: begin
                  cmd.start = 1'b1;
                  state_in  = nap_pkg::ST_IDLE;
               end
            endcase
         end
         nap_pkg::ST_MOD: begin
            cmd.mod_step = 1'b1;
            if (sts.mod_last) begin
               state_in = nap_pkg::ST_TICK_CHECK;
            end
         end
         nap_pkg::ST_TICK_CHECK: begin
            if (sts.rem_zero && !sts.list_empty) begin
               cmd.step_pos = 1'b1;
               state_in     = nap_pkg::ST_EMIT;
            end else begin
               state_in = nap_pkg::ST_IDLE;
            end
         end
         nap_pkg::ST_RM_READ: begin
            if (sts.rm_done) begin
               cmd.rm_finish = 1'b1;
               state_in      = nap_pkg::ST_IDLE;
            end else begin
               cmd.rm_read = 1'b1;
               state_in    = nap_pkg::ST_RM_CHECK;
            end
         end
         nap_pkg::ST_RM_CHECK: begin
            cmd.rm_check = 1'b1;
            state_in     = nap_pkg::ST_RM_READ;
         end
         nap_pkg::ST_EMIT: begin
            // Wait for the output register to free up before loading the next beat.
            if (!sts.rsp_busy || rsp_ready) begin
               cmd.load_rsp = 1'b1;
               state_in     = nap_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = nap_pkg::ST_IDLE;
         end
      endcase
   end

endmodule

### src/nap_datapath.sv
// Datapath: held-note memory, list counters, modulo unit and output register.
`timescale 1ns / 1ps

module nap_datapath #(
   parameter int NOTE_SLOTS = nap_pkg::NOTE_SLOTS_DEFAULT
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic [1:0]                    req_op,
   input  logic [nap_pkg::NOTE_W-1:0]    req_note,
   input  logic [nap_pkg::VEL_W-1:0]     req_velocity,
   input  logic [nap_pkg::COUNT_W-1:0]   req_clock_count,
   input  logic                          csr_write_enable,
   input  logic [nap_pkg::DIV_W-1:0]     csr_write_data,
   input  logic                          rsp_ready,
   output logic                          rsp_valid,
   output logic [nap_pkg::NOTE_W-1:0]    rsp_play_note,
   output logic [nap_pkg::VEL_W-1:0]     rsp_play_velocity,
   input  nap_pkg::cmd_type              cmd,
   output nap_pkg::sts_type              sts
);

   localparam int CW = $clog2(NOTE_SLOTS + 1);
   localparam int PW = $clog2(NOTE_SLOTS);

   logic [nap_pkg::ENTRY_W-1:0] mem [NOTE_SLOTS];
   logic [nap_pkg::ENTRY_W-1:0] rdata_ff;

   nap_pkg::op_type                op_ff;
   logic [nap_pkg::NOTE_W-1:0]     note_ff;
   logic [nap_pkg::VEL_W-1:0]      vel_ff;
   logic [nap_pkg::COUNT_W-1:0]    bits_ff, bits_in;
   logic [nap_pkg::DIV_W-1:0]      rem_ff, rem_in;
   logic [nap_pkg::MOD_CNT_W-1:0]  iter_ff, iter_in;
   logic [nap_pkg::DIV_W-1:0]      div_ff;
   logic [CW-1:0]                  count_ff, count_in;
   logic [PW-1:0]                  pos_ff, pos_in;
   logic [CW-1:0]                  rd_ff, rd_in;
   logic [CW-1:0]                  wr_ff, wr_in;
   logic                           rsp_valid_ff, rsp_valid_in;
   logic [nap_pkg::NOTE_W-1:0]     rsp_note_ff;
   logic [nap_pkg::VEL_W-1:0]      rsp_vel_ff;

   logic [nap_pkg::DIV_W-1:0]      div_eff;
   logic [nap_pkg::DIV_W:0]        trial1, trial2;
   logic [nap_pkg::DIV_W-1:0]      rem_mid;
   logic [CW-1:0]                  pos_inc;
   logic [PW-1:0]                  pos_new;
   logic                           list_full;
   logic                           keep;
   logic                           mem_we;
   logic [PW-1:0]                  mem_waddr;
   logic [nap_pkg::ENTRY_W-1:0]    mem_wdata;
   logic [PW-1:0]                  mem_raddr;

   // A division of zero behaves as one, so every tick steps.
   assign div_eff = (div_ff == '0) ? nap_pkg::DIV_W'(1) : div_ff;

   // Restoring remainder, two bits of the count per cycle.
   always_comb begin
      trial1 = {rem_ff, bits_ff[nap_pkg::COUNT_W-1]};
      if (trial1 >= {1'b0, div_eff}) begin
         trial1 = trial1 - {1'b0, div_eff};
      end
      rem_mid = trial1[nap_pkg::DIV_W-1:0];
      trial2  = {rem_mid, bits_ff[nap_pkg::COUNT_W-2]};
      if (trial2 >= {1'b0, div_eff}) begin
         trial2 = trial2 - {1'b0, div_eff};
      end
   end

   assign pos_inc   = CW'(pos_ff) + CW'(1);
   assign pos_new   = (pos_inc >= count_ff) ? '0 : pos_inc[PW-1:0];
   assign list_full = (count_ff == CW'(NOTE_SLOTS));
   assign keep      = (rdata_ff[nap_pkg::ENTRY_W-1:nap_pkg::VEL_W] != note_ff);

   always_comb begin
      bits_in      = bits_ff;
      rem_in       = rem_ff;
      iter_in      = iter_ff;
      count_in     = count_ff;
      pos_in       = pos_ff;
      rd_in        = rd_ff;
      wr_in        = wr_ff;
      mem_we       = 1'b0;
      mem_waddr    = count_ff[PW-1:0];
      mem_wdata    = {note_ff, vel_ff};
      mem_raddr    = pos_ff;
      rsp_valid_in = rsp_valid_ff & ~rsp_ready;
      if (cmd.load_item) begin
         bits_in = req_clock_count;
         rem_in  = '0;
         iter_in = nap_pkg::MOD_CNT_W'(nap_pkg::MOD_STEPS - 1);
         rd_in   = '0;
         wr_in   = '0;
      end
      if (cmd.mod_step) begin
         bits_in = {bits_ff[nap_pkg::COUNT_W-3:0], 2'b00};
         rem_in  = trial2[nap_pkg::DIV_W-1:0];
         iter_in = iter_ff - nap_pkg::MOD_CNT_W'(1);
      end
      if (cmd.add_note && !list_full) begin
         mem_we   = 1'b1;
         count_in = count_ff + CW'(1);
      end
      if (cmd.start) begin
         pos_in = '0;
      end
      if (cmd.rm_read) begin
         mem_raddr = rd_ff[PW-1:0];
      end
      if (cmd.rm_check) begin
         rd_in = rd_ff + CW'(1);
         if (keep) begin
            mem_we    = 1'b1;
            mem_waddr = wr_ff[PW-1:0];
            mem_wdata = rdata_ff;
            wr_in     = wr_ff + CW'(1);
         end
      end
      if (cmd.rm_finish) begin
         count_in = wr_ff;
      end
      if (cmd.step_pos) begin
         // The read at the new position stays selected until the beat is loaded.
         pos_in    = pos_new;
         mem_raddr = pos_new;
      end
      if (cmd.load_rsp) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_waddr] <= mem_wdata;
      end
      rdata_ff <= mem[mem_raddr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         pos_ff       <= '0;
         div_ff       <= nap_pkg::DIV_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         pos_ff       <= pos_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_write_enable) begin
            div_ff <= csr_write_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_item) begin
         op_ff   <= nap_pkg::op_type'(req_op);
         note_ff <= req_note;
         vel_ff  <= req_velocity;
      end
      if (cmd.load_rsp) begin
         rsp_note_ff <= rdata_ff[nap_pkg::ENTRY_W-1:nap_pkg::VEL_W];
         rsp_vel_ff  <= rdata_ff[nap_pkg::VEL_W-1:0];
      end
      bits_ff <= bits_in;
      rem_ff  <= rem_in;
      iter_ff <= iter_in;
      rd_ff   <= rd_in;
      wr_ff   <= wr_in;
   end

   assign sts.op         = op_ff;
   assign sts.mod_last   = (iter_ff == '0);
   assign sts.rem_zero   = (rem_ff == '0);
   assign sts.list_empty = (count_ff == '0);
   assign sts.rm_done    = (rd_ff == count_ff);
   assign sts.rsp_busy   = rsp_valid_ff;

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_play_note     = rsp_note_ff;
   assign rsp_play_velocity = rsp_vel_ff;

endmodule
